// ----- hdl/dpsv_pkg.sv -----
// dpsv_pkg: shared widths, register map, constants and stage types
// for the pixel to scattering vector pipeline; no dependencies
package dpsv_pkg;

    localparam int INDEX_BITS   = 24;
    localparam int CORDIC_STEPS = 24;

    localparam int WIDTH_W  = 16;
    localparam int PITCH_W  = 24;
    localparam int BEAM_W   = 16;
    localparam int SDIST_W  = 32;
    localparam int K_W      = 31;
    localparam int TRIG_W   = 31;

    localparam int IN_TDATA_W  = ((INDEX_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 320;

    localparam int OFF_W   = INDEX_BITS + 2;
    localparam int DIST_W  = PITCH_W + 1 + OFF_W;
    localparam int VEC_W   = DIST_W + 2;
    localparam int ANG_W   = 32;
    localparam int ROT_W   = 34;
    localparam int ROTZ_W  = 33;
    localparam int MIX_W   = 36;
    localparam int KP_W    = K_W + 1 + MIX_W;
    localparam int Q_W     = 32;
    localparam int MAG_W   = 31;
    localparam int SQ_W    = 64;
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int SQRT_LANES = 3;

    localparam logic [31:0] GAIN_Q32 = 32'h9B74EDA8;
    localparam logic signed [ROT_W-1:0] INV_GAIN_Q30 = ROT_W'(652032874);

    // register map
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_IDX_W  = 3;
    localparam logic [CFG_IDX_W-1:0] REG_DETECTOR_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_PITCH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BEAM_COL        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BEAM_ROW        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_DISTANCE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WAVENUMBER      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INCIDENCE_COS   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INCIDENCE_SIN   = 3'd7;

    localparam logic [WIDTH_W-1:0] RST_DETECTOR_WIDTH  = 16'd1024;
    localparam logic [PITCH_W-1:0] RST_PIXEL_PITCH     = 24'd11272;
    localparam logic [BEAM_W-1:0]  RST_BEAM_COL        = 16'd512;
    localparam logic [BEAM_W-1:0]  RST_BEAM_ROW        = 16'd512;
    localparam logic [SDIST_W-1:0] RST_SAMPLE_DISTANCE = 32'd327680000;
    localparam logic [K_W-1:0]     RST_WAVENUMBER      = 31'd1053609165;
    localparam logic [TRIG_W-1:0]  RST_INCIDENCE_COS   = 31'd1073741824;
    localparam logic [TRIG_W-1:0]  RST_INCIDENCE_SIN   = 31'd0;

    typedef struct packed {
        logic [INDEX_BITS-1:0] idx;
        logic [WIDTH_W-1:0]    rem;
        logic [INDEX_BITS-1:0] quo;
    } div_t;

    typedef struct packed {
        logic signed [DIST_W-1:0] dx;
        logic signed [DIST_W-1:0] dy;
    } mul_t;

    typedef struct packed {
        logic signed [VEC_W-1:0]  x;
        logic signed [VEC_W-1:0]  y;
        logic signed [ANG_W-1:0]  z;
        logic                     yz;
        logic signed [DIST_W-1:0] dy;
        logic signed [ANG_W-1:0]  th;
    } vec_t;

    typedef struct packed {
        logic [VEC_W-1:0]         mag;
        logic [VEC_W-1:0]         ph;
        logic [63:0]              pl;
        logic                     yz;
        logic signed [DIST_W-1:0] dy;
        logic signed [ANG_W-1:0]  th;
    } gain_t;

    typedef struct packed {
        logic signed [ROT_W-1:0]  x;
        logic signed [ROT_W-1:0]  y;
        logic signed [ROTZ_W-1:0] z;
    } cs_t;

    typedef struct packed {
        cs_t                     t;
        cs_t                     a;
        logic signed [ANG_W-1:0] th;
        logic signed [ANG_W-1:0] al;
    } rot_t;

    typedef struct packed {
        logic signed [MIX_W-1:0] cx;
        logic signed [MIX_W-1:0] cy;
        logic signed [MIX_W-1:0] cz;
        logic signed [MIX_W-1:0] cs;
        logic signed [MIX_W-1:0] cd;
        logic signed [ANG_W-1:0] th;
        logic signed [ANG_W-1:0] al;
    } mix_t;

    typedef struct packed {
        logic signed [KP_W-1:0]  px;
        logic signed [KP_W-1:0]  py;
        logic signed [KP_W-1:0]  pz;
        logic signed [KP_W-1:0]  ps;
        logic signed [KP_W-1:0]  pd;
        logic signed [ANG_W-1:0] th;
        logic signed [ANG_W-1:0] al;
    } kp_t;

    typedef struct packed {
        logic signed [ANG_W-1:0] theta;
        logic signed [ANG_W-1:0] alpha;
        logic signed [Q_W-1:0]   qx;
        logic signed [Q_W-1:0]   qy;
        logic signed [Q_W-1:0]   qz;
        logic signed [Q_W-1:0]   qs;
        logic signed [Q_W-1:0]   qd;
    } res_t;

    typedef struct packed {
        logic [SQ_W-1:0] sx;
        logic [SQ_W-1:0] sy;
        logic [SQ_W-1:0] ss;
        logic [SQ_W-1:0] sd;
        res_t            res;
    } sq_t;

    typedef struct packed {
        logic [SQ_W-1:0] par2;
        logic [SQ_W-1:0] ss;
        logic [SQ_W-1:0] sd;
        res_t            res;
    } par_t;

    typedef struct packed {
        logic [SQRT_LANES-1:0][SQ_W-1:0] n;
        logic [SQRT_LANES-1:0][SQ_W-1:0] r;
        res_t                            res;
    } sqrt_t;

    typedef struct packed {
        logic [OUT_TDATA_W-317-1:0] pad;
        logic [MAG_W-1:0]           q_total_diff;
        logic [MAG_W-1:0]           q_total_sum;
        logic [Q_W-1:0]             qz_diff;
        logic [Q_W-1:0]             qz_sum;
        logic [MAG_W-1:0]           q_parallel;
        logic [Q_W-1:0]             q_z;
        logic [Q_W-1:0]             q_y;
        logic [Q_W-1:0]             q_x;
        logic [ANG_W-1:0]           exit_alpha;
        logic [ANG_W-1:0]           exit_theta;
    } out_t;

    // arctangent of 2^-i, Q3.29
    function automatic logic [ANG_W-1:0] atan_q29(input int i);
        logic [ANG_W-1:0] v;
        case (i)
            0:       v = 32'd421657428;
            1:       v = 32'd248918915;
            2:       v = 32'd131521918;
            3:       v = 32'd66762579;
            4:       v = 32'd33510843;
            5:       v = 32'd16771758;
            6:       v = 32'd8387925;
            7:       v = 32'd4194219;
            8:       v = 32'd2097141;
            9:       v = 32'd1048575;
            10:      v = 32'd524288;
            11:      v = 32'd262144;
            12:      v = 32'd131072;
            13:      v = 32'd65536;
            14:      v = 32'd32768;
            15:      v = 32'd16384;
            16:      v = 32'd8192;
            17:      v = 32'd4096;
            18:      v = 32'd2048;
            19:      v = 32'd1024;
            20:      v = 32'd512;
            21:      v = 32'd256;
            22:      v = 32'd128;
            23:      v = 32'd64;
            24:      v = 32'd32;
            25:      v = 32'd16;
            26:      v = 32'd8;
            27:      v = 32'd4;
            28:      v = 32'd2;
            29:      v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // one vectoring micro-rotation, frozen when y started at zero
    function automatic vec_t vec_step(input vec_t a, input int i);
        vec_t r;
        logic signed [VEC_W-1:0] xv;
        logic signed [VEC_W-1:0] yv;
        logic signed [VEC_W-1:0] xs;
        logic signed [VEC_W-1:0] ys;
        logic signed [ANG_W-1:0] at;
        r  = a;
        xv = a.x;
        yv = a.y;
        xs = xv >>> i;
        ys = yv >>> i;
        at = $signed(atan_q29(i));
        if (!a.yz)
        begin
            if (!yv[VEC_W-1])
            begin
                r.x = xv + ys;
                r.y = yv - xs;
                r.z = a.z + at;
            end
            else
            begin
                r.x = xv - ys;
                r.y = yv + xs;
                r.z = a.z - at;
            end
        end
        return r;
    endfunction

    // one rotation-mode micro-rotation
    function automatic cs_t rot_step(input cs_t a, input int i);
        cs_t r;
        logic signed [ROT_W-1:0]  xv;
        logic signed [ROT_W-1:0]  yv;
        logic signed [ROT_W-1:0]  xs;
        logic signed [ROT_W-1:0]  ys;
        logic signed [ROTZ_W-1:0] at;
        xv = a.x;
        yv = a.y;
        xs = xv >>> i;
        ys = yv >>> i;
        at = $signed({1'b0, atan_q29(i)});
        if (!a.z[ROTZ_W-1])
        begin
            r.x = xv - ys;
            r.y = yv + xs;
            r.z = a.z - at;
        end
        else
        begin
            r.x = xv + ys;
            r.y = yv - xs;
            r.z = a.z + at;
        end
        return r;
    endfunction

    // floor shift by 30 and clamp to the signed 32-bit range
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [KP_W-1:0] p);
        logic signed [KP_W-1:0] s;
        logic signed [Q_W-1:0]  v;
        s = p >>> 30;
        if (s > $signed({{(KP_W-31){1'b0}}, {31{1'b1}}}))
            v = {1'b0, {31{1'b1}}};
        else if (s < $signed({{(KP_W-31){1'b1}}, 31'b0}))
            v = {1'b1, 31'b0};
        else
            v = s[Q_W-1:0];
        return v;
    endfunction

    // one digit of the integer square root, on every lane
    function automatic sqrt_t sqrt_step(input sqrt_t a, input int k);
        sqrt_t r;
        logic [SQ_W-1:0] b;
        logic [SQ_W-1:0] t;
        r = a;
        b = SQ_W'(1) << (SQ_W - 2 - 2 * k);
        for (int l = 0; l < SQRT_LANES; l++)
        begin
            t = a.r[l] + b;
            if (a.n[l] >= t)
            begin
                r.n[l] = a.n[l] - t;
                r.r[l] = (a.r[l] >> 1) + b;
            end
            else
            begin
                r.r[l] = a.r[l] >> 1;
            end
        end
        return r;
    endfunction

    function automatic logic [MAG_W-1:0] sat_mag(input logic [SQ_W-1:0] r);
        logic [MAG_W-1:0] v;
        if (|r[SQ_W-1:MAG_W])
            v = {MAG_W{1'b1}};
        else
            v = r[MAG_W-1:0];
        return v;
    endfunction

endpackage

// ----- hdl/detector_pixel_to_scattering_vector.sv -----
// detector_pixel_to_scattering_vector: pixel index to GISAXS exit angles and q terms
// depends on dpsv_pkg (widths, register map, stage types, cordic and root steps)
//
// channel   | dir | handshake              | word
// s_axis    | in  | tvalid / tready        | tdata: pixel_index
// m_axis    | out | tvalid / tready        | tdata: angles, q terms, magnitudes
// apb       | in  | psel, penable, pwrite  | 8 registers at 4*i, pready always high
//
// one word per clock sustained while no word is parked in the skid register; the path runs
// through the divider, the three cordic chains and the root chain
// reset clears valid bits and restores the register defaults
// a stalled output parks one word in a skid register; the pipeline then holds
module detector_pixel_to_scattering_vector
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [dpsv_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // pixel_index
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // exit_theta, exit_alpha, q_x, q_y, q_z, q_parallel, qz_sum, qz_diff,
    // q_total_sum, q_total_diff, zero pad
    output logic [dpsv_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dpsv_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int IB = dpsv_pkg::INDEX_BITS;
    localparam int CS = dpsv_pkg::CORDIC_STEPS;
    localparam int SS = dpsv_pkg::SQRT_STEPS;

    logic [dpsv_pkg::WIDTH_W-1:0] width_reg;
    logic [dpsv_pkg::PITCH_W-1:0] pitch_reg;
    logic [dpsv_pkg::BEAM_W-1:0]  bcol_reg;
    logic [dpsv_pkg::BEAM_W-1:0]  brow_reg;
    logic [dpsv_pkg::SDIST_W-1:0] sdist_reg;
    logic [dpsv_pkg::K_W-1:0]     k_reg;
    logic [dpsv_pkg::TRIG_W-1:0]  icos_reg;
    logic [dpsv_pkg::TRIG_W-1:0]  isin_reg;

    logic                               cfg_wr;
    logic [dpsv_pkg::CFG_IDX_W-1:0]     cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[dpsv_pkg::CFG_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= dpsv_pkg::RST_DETECTOR_WIDTH;
            pitch_reg <= dpsv_pkg::RST_PIXEL_PITCH;
            bcol_reg  <= dpsv_pkg::RST_BEAM_COL;
            brow_reg  <= dpsv_pkg::RST_BEAM_ROW;
            sdist_reg <= dpsv_pkg::RST_SAMPLE_DISTANCE;
            k_reg     <= dpsv_pkg::RST_WAVENUMBER;
            icos_reg  <= dpsv_pkg::RST_INCIDENCE_COS;
            isin_reg  <= dpsv_pkg::RST_INCIDENCE_SIN;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                dpsv_pkg::REG_DETECTOR_WIDTH:  width_reg <= pwdata[dpsv_pkg::WIDTH_W-1:0];
                dpsv_pkg::REG_PIXEL_PITCH:     pitch_reg <= pwdata[dpsv_pkg::PITCH_W-1:0];
                dpsv_pkg::REG_BEAM_COL:        bcol_reg  <= pwdata[dpsv_pkg::BEAM_W-1:0];
                dpsv_pkg::REG_BEAM_ROW:        brow_reg  <= pwdata[dpsv_pkg::BEAM_W-1:0];
                dpsv_pkg::REG_SAMPLE_DISTANCE: sdist_reg <= pwdata[dpsv_pkg::SDIST_W-1:0];
                dpsv_pkg::REG_WAVENUMBER:      k_reg     <= pwdata[dpsv_pkg::K_W-1:0];
                dpsv_pkg::REG_INCIDENCE_COS:   icos_reg  <= pwdata[dpsv_pkg::TRIG_W-1:0];
                dpsv_pkg::REG_INCIDENCE_SIN:   isin_reg  <= pwdata[dpsv_pkg::TRIG_W-1:0];
                default:                       ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            dpsv_pkg::REG_DETECTOR_WIDTH:  prdata = 32'(width_reg);
            dpsv_pkg::REG_PIXEL_PITCH:     prdata = 32'(pitch_reg);
            dpsv_pkg::REG_BEAM_COL:        prdata = 32'(bcol_reg);
            dpsv_pkg::REG_BEAM_ROW:        prdata = 32'(brow_reg);
            dpsv_pkg::REG_SAMPLE_DISTANCE: prdata = 32'(sdist_reg);
            dpsv_pkg::REG_WAVENUMBER:      prdata = 32'(k_reg);
            dpsv_pkg::REG_INCIDENCE_COS:   prdata = 32'(icos_reg);
            dpsv_pkg::REG_INCIDENCE_SIN:   prdata = 32'(isin_reg);
            default:                       prdata = 32'd0;
        endcase
    end

    // pipeline advance
    logic ce;
    logic in_acc;
    logic skid_v_reg;

    assign ce            = ~skid_v_reg;
    assign s_axis_tready = ce;
    assign in_acc        = s_axis_tvalid & ce;

    // row / column divider, one quotient bit per stage
    dpsv_pkg::div_t div_reg  [IB];
    dpsv_pkg::div_t div_next [IB];
    logic           div_v_reg [IB];

    for (genvar k = 0; k < IB; k++)
    begin : g_div
        dpsv_pkg::div_t             prev;
        logic                       pv;
        logic [dpsv_pkg::WIDTH_W:0] trial;
        logic [dpsv_pkg::WIDTH_W:0] diff;
        logic                       ge;

        if (k == 0)
        begin : g_head
            always_comb
            begin
                prev     = '0;
                prev.idx = s_axis_tdata[IB-1:0];
            end
            assign pv = in_acc;
        end
        else
        begin : g_body
            assign prev = div_reg[k-1];
            assign pv   = div_v_reg[k-1];
        end

        assign trial = {prev.rem, prev.idx[IB-1-k]};
        assign diff  = trial - {1'b0, width_reg};
        assign ge    = trial >= {1'b0, width_reg};

        always_comb
        begin
            div_next[k]     = prev;
            div_next[k].rem = ge ? diff[dpsv_pkg::WIDTH_W-1:0] : trial[dpsv_pkg::WIDTH_W-1:0];
            div_next[k].quo = {prev.quo[IB-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                div_v_reg[k] <= 1'b0;
            else if (ce)
                div_v_reg[k] <= pv;
        end

        always_ff @(posedge clk)
        begin
            if (ce)
                div_reg[k] <= div_next[k];
        end
    end

    // pixel offsets scaled by pitch
    dpsv_pkg::div_t                     dtail;
    logic [IB-1:0]                      col_u;
    logic [IB-1:0]                      row_u;
    logic signed [dpsv_pkg::OFF_W-1:0]  ox;
    logic signed [dpsv_pkg::OFF_W-1:0]  oy;
    logic signed [dpsv_pkg::PITCH_W:0]  pitch_s;
    dpsv_pkg::mul_t                     mul_next;
    dpsv_pkg::mul_t                     mul_reg;
    logic                               mul_v_reg;

    assign dtail   = div_reg[IB-1];
    assign col_u   = (width_reg == '0) ? dtail.idx : IB'(dtail.rem);
    assign row_u   = (width_reg == '0) ? '0 : dtail.quo;
    assign ox      = $signed({2'b00, col_u}) + dpsv_pkg::OFF_W'(1)
                     - $signed(dpsv_pkg::OFF_W'(bcol_reg));
    assign oy      = $signed({2'b00, row_u}) + dpsv_pkg::OFF_W'(1)
                     - $signed(dpsv_pkg::OFF_W'(brow_reg));
    assign pitch_s = $signed({1'b0, pitch_reg});

    always_comb
    begin
        mul_next.dx = pitch_s * ox;
        mul_next.dy = pitch_s * oy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_v_reg <= 1'b0;
        else if (ce)
            mul_v_reg <= div_v_reg[IB-1];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            mul_reg <= mul_next;
    end

    // theta vectoring: (sample distance, column offset)
    dpsv_pkg::vec_t v1_reg  [CS];
    dpsv_pkg::vec_t v1_next [CS];
    logic           v1_v_reg [CS];

    for (genvar i = 0; i < CS; i++)
    begin : g_v1
        dpsv_pkg::vec_t prev;
        logic           pv;

        if (i == 0)
        begin : g_head
            always_comb
            begin
                prev    = '0;
                prev.x  = $signed(dpsv_pkg::VEC_W'(sdist_reg));
                prev.y  = {{(dpsv_pkg::VEC_W-dpsv_pkg::DIST_W){mul_reg.dx[dpsv_pkg::DIST_W-1]}},
                           mul_reg.dx};
                prev.yz = (mul_reg.dx == '0);
                prev.dy = mul_reg.dy;
            end
            assign pv = mul_v_reg;
        end
        else
        begin : g_body
            assign prev = v1_reg[i-1];
            assign pv   = v1_v_reg[i-1];
        end

        assign v1_next[i] = dpsv_pkg::vec_step(prev, i);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v1_v_reg[i] <= 1'b0;
            else if (ce)
                v1_v_reg[i] <= pv;
        end

        always_ff @(posedge clk)
        begin
            if (ce)
                v1_reg[i] <= v1_next[i];
        end
    end

    // gain correction of the in-plane radius, split into two 32-bit products
    dpsv_pkg::vec_t                  vt1;
    dpsv_pkg::gain_t                 g1_next;
    dpsv_pkg::gain_t                 g1_reg;
    logic                            g1_v_reg;
    logic [dpsv_pkg::VEC_W-1:0]      quad_next;
    logic [dpsv_pkg::VEC_W-1:0]      quad_reg;
    logic signed [dpsv_pkg::DIST_W-1:0] g2_dy_reg;
    logic signed [dpsv_pkg::ANG_W-1:0]  g2_th_reg;
    logic                            g2_v_reg;

    assign vt1 = v1_reg[CS-1];

    always_comb
    begin
        g1_next     = '0;
        g1_next.mag = vt1.x[dpsv_pkg::VEC_W-1] ? '0 : vt1.x;
        g1_next.ph  = dpsv_pkg::VEC_W'(g1_next.mag[dpsv_pkg::VEC_W-1:32])
                      * dpsv_pkg::VEC_W'(dpsv_pkg::GAIN_Q32);
        g1_next.pl  = g1_next.mag[31:0] * dpsv_pkg::GAIN_Q32;
        g1_next.yz  = vt1.yz;
        g1_next.dy  = vt1.dy;
        g1_next.th  = vt1.z;
    end

    assign quad_next = g1_reg.yz ? g1_reg.mag
                                 : g1_reg.ph + dpsv_pkg::VEC_W'(g1_reg.pl[63:32]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_v_reg <= 1'b0;
            g2_v_reg <= 1'b0;
        end
        else if (ce)
        begin
            g1_v_reg <= v1_v_reg[CS-1];
            g2_v_reg <= g1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            g1_reg    <= g1_next;
            quad_reg  <= quad_next;
            g2_dy_reg <= g1_reg.dy;
            g2_th_reg <= g1_reg.th;
        end
    end

    // alpha vectoring: (radius, row offset)
    dpsv_pkg::vec_t v2_reg  [CS];
    dpsv_pkg::vec_t v2_next [CS];
    logic           v2_v_reg [CS];

    for (genvar i = 0; i < CS; i++)
    begin : g_v2
        dpsv_pkg::vec_t prev;
        logic           pv;

        if (i == 0)
        begin : g_head
            always_comb
            begin
                prev    = '0;
                prev.x  = $signed(quad_reg);
                prev.y  = {{(dpsv_pkg::VEC_W-dpsv_pkg::DIST_W){g2_dy_reg[dpsv_pkg::DIST_W-1]}},
                           g2_dy_reg};
                prev.yz = (g2_dy_reg == '0);
                prev.dy = g2_dy_reg;
                prev.th = g2_th_reg;
            end
            assign pv = g2_v_reg;
        end
        else
        begin : g_body
            assign prev = v2_reg[i-1];
            assign pv   = v2_v_reg[i-1];
        end

        assign v2_next[i] = dpsv_pkg::vec_step(prev, i);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v2_v_reg[i] <= 1'b0;
            else if (ce)
                v2_v_reg[i] <= pv;
        end

        always_ff @(posedge clk)
        begin
            if (ce)
                v2_reg[i] <= v2_next[i];
        end
    end

    // cos / sin of both angles side by side
    dpsv_pkg::rot_t rt_reg  [CS];
    dpsv_pkg::rot_t rt_next [CS];
    logic           rt_v_reg [CS];
    dpsv_pkg::vec_t vt2;

    assign vt2 = v2_reg[CS-1];

    for (genvar i = 0; i < CS; i++)
    begin : g_rot
        dpsv_pkg::rot_t prev;
        logic           pv;

        if (i == 0)
        begin : g_head
            always_comb
            begin
                prev     = '0;
                prev.t.x = dpsv_pkg::INV_GAIN_Q30;
                prev.t.z = {vt2.th[dpsv_pkg::ANG_W-1], vt2.th};
                prev.a.x = dpsv_pkg::INV_GAIN_Q30;
                prev.a.z = {vt2.z[dpsv_pkg::ANG_W-1], vt2.z};
                prev.th  = vt2.th;
                prev.al  = vt2.z;
            end
            assign pv = v2_v_reg[CS-1];
        end
        else
        begin : g_body
            assign prev = rt_reg[i-1];
            assign pv   = rt_v_reg[i-1];
        end

        always_comb
        begin
            rt_next[i]   = prev;
            rt_next[i].t = dpsv_pkg::rot_step(prev.t, i);
            rt_next[i].a = dpsv_pkg::rot_step(prev.a, i);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rt_v_reg[i] <= 1'b0;
            else if (ce)
                rt_v_reg[i] <= pv;
        end

        always_ff @(posedge clk)
        begin
            if (ce)
                rt_reg[i] <= rt_next[i];
        end
    end

    // direction cosines and sine sums
    dpsv_pkg::rot_t                       rtl;
    logic signed [dpsv_pkg::ROT_W-1:0]    ct;
    logic signed [dpsv_pkg::ROT_W-1:0]    st;
    logic signed [dpsv_pkg::ROT_W-1:0]    ca;
    logic signed [dpsv_pkg::ROT_W-1:0]    sa;
    logic signed [2*dpsv_pkg::ROT_W-1:0]  pcc;
    logic signed [2*dpsv_pkg::ROT_W-1:0]  pcs;
    logic signed [dpsv_pkg::MIX_W-1:0]    sa_x;
    logic signed [dpsv_pkg::MIX_W-1:0]    abs_sa;
    logic signed [dpsv_pkg::MIX_W-1:0]    isin_x;
    dpsv_pkg::mix_t                       p1_next;
    dpsv_pkg::mix_t                       p1_reg;
    dpsv_pkg::mix_t                       p2_next;
    dpsv_pkg::mix_t                       p2_reg;
    logic                                 p1_v_reg;
    logic                                 p2_v_reg;

    assign rtl    = rt_reg[CS-1];
    assign ct     = rtl.t.x;
    assign st     = rtl.t.y;
    assign ca     = rtl.a.x;
    assign sa     = rtl.a.y;
    assign pcc    = ca * ct;
    assign pcs    = ca * st;
    assign sa_x   = {{(dpsv_pkg::MIX_W-dpsv_pkg::ROT_W){sa[dpsv_pkg::ROT_W-1]}}, sa};
    assign abs_sa = sa_x[dpsv_pkg::MIX_W-1] ? -sa_x : sa_x;
    assign isin_x = $signed({{(dpsv_pkg::MIX_W-dpsv_pkg::TRIG_W){1'b0}}, isin_reg});

    always_comb
    begin
        p1_next.cx = dpsv_pkg::MIX_W'(pcc >>> 30);
        p1_next.cy = dpsv_pkg::MIX_W'(pcs >>> 30);
        p1_next.cz = sa_x + isin_x;
        p1_next.cs = abs_sa + isin_x;
        p1_next.cd = isin_x - abs_sa;
        p1_next.th = rtl.th;
        p1_next.al = rtl.al;
    end

    always_comb
    begin
        p2_next    = p1_reg;
        p2_next.cx = p1_reg.cx
                     - $signed({{(dpsv_pkg::MIX_W-dpsv_pkg::TRIG_W){1'b0}}, icos_reg});
    end

    // wavenumber products
    logic signed [dpsv_pkg::K_W:0] k_s;
    dpsv_pkg::kp_t                 p3_next;
    dpsv_pkg::kp_t                 p3_reg;
    logic                          p3_v_reg;

    assign k_s = $signed({1'b0, k_reg});

    always_comb
    begin
        p3_next.px = k_s * p2_reg.cx;
        p3_next.py = k_s * p2_reg.cy;
        p3_next.pz = k_s * p2_reg.cz;
        p3_next.ps = k_s * p2_reg.cs;
        p3_next.pd = k_s * p2_reg.cd;
        p3_next.th = p2_reg.th;
        p3_next.al = p2_reg.al;
    end

    dpsv_pkg::res_t p4_next;
    dpsv_pkg::res_t p4_reg;
    logic           p4_v_reg;

    always_comb
    begin
        p4_next.theta = p3_reg.th;
        p4_next.alpha = p3_reg.al;
        p4_next.qx    = dpsv_pkg::sat_q(p3_reg.px);
        p4_next.qy    = dpsv_pkg::sat_q(p3_reg.py);
        p4_next.qz    = dpsv_pkg::sat_q(p3_reg.pz);
        p4_next.qs    = dpsv_pkg::sat_q(p3_reg.ps);
        p4_next.qd    = dpsv_pkg::sat_q(p3_reg.pd);
    end

    // squares and sums for the magnitudes
    dpsv_pkg::sq_t  p5_next;
    dpsv_pkg::sq_t  p5_reg;
    logic           p5_v_reg;
    dpsv_pkg::par_t p6_next;
    dpsv_pkg::par_t p6_reg;
    logic           p6_v_reg;
    dpsv_pkg::sqrt_t p7_next;
    dpsv_pkg::sqrt_t p7_reg;
    logic            p7_v_reg;

    always_comb
    begin
        p5_next.sx  = p4_reg.qx * p4_reg.qx;
        p5_next.sy  = p4_reg.qy * p4_reg.qy;
        p5_next.ss  = p4_reg.qs * p4_reg.qs;
        p5_next.sd  = p4_reg.qd * p4_reg.qd;
        p5_next.res = p4_reg;
    end

    always_comb
    begin
        p6_next.par2 = p5_reg.sx + p5_reg.sy;
        p6_next.ss   = p5_reg.ss;
        p6_next.sd   = p5_reg.sd;
        p6_next.res  = p5_reg.res;
    end

    always_comb
    begin
        p7_next      = '0;
        p7_next.n[0] = p6_reg.par2;
        p7_next.n[1] = p6_reg.par2 + p6_reg.ss;
        p7_next.n[2] = p6_reg.par2 + p6_reg.sd;
        p7_next.res  = p6_reg.res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            p4_v_reg <= 1'b0;
            p5_v_reg <= 1'b0;
            p6_v_reg <= 1'b0;
            p7_v_reg <= 1'b0;
        end
        else if (ce)
        begin
            p1_v_reg <= rt_v_reg[CS-1];
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            p4_v_reg <= p3_v_reg;
            p5_v_reg <= p4_v_reg;
            p6_v_reg <= p5_v_reg;
            p7_v_reg <= p6_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            p3_reg <= p3_next;
            p4_reg <= p4_next;
            p5_reg <= p5_next;
            p6_reg <= p6_next;
            p7_reg <= p7_next;
        end
    end

    // integer square roots, three lanes, one result bit per stage
    dpsv_pkg::sqrt_t sr_reg  [SS];
    dpsv_pkg::sqrt_t sr_next [SS];
    logic            sr_v_reg [SS];

    for (genvar k = 0; k < SS; k++)
    begin : g_sqrt
        dpsv_pkg::sqrt_t prev;
        logic            pv;

        if (k == 0)
        begin : g_head
            assign prev = p7_reg;
            assign pv   = p7_v_reg;
        end
        else
        begin : g_body
            assign prev = sr_reg[k-1];
            assign pv   = sr_v_reg[k-1];
        end

        assign sr_next[k] = dpsv_pkg::sqrt_step(prev, k);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sr_v_reg[k] <= 1'b0;
            else if (ce)
                sr_v_reg[k] <= pv;
        end

        always_ff @(posedge clk)
        begin
            if (ce)
                sr_reg[k] <= sr_next[k];
        end
    end

    // output register and skid
    dpsv_pkg::sqrt_t tail;
    dpsv_pkg::out_t  tail_word;
    dpsv_pkg::out_t  out_reg;
    dpsv_pkg::out_t  skid_reg;
    logic            out_v_reg;
    logic            push;
    logic            take;

    assign tail = sr_reg[SS-1];

    always_comb
    begin
        tail_word              = '0;
        tail_word.exit_theta   = tail.res.theta;
        tail_word.exit_alpha   = tail.res.alpha;
        tail_word.q_x          = tail.res.qx;
        tail_word.q_y          = tail.res.qy;
        tail_word.q_z          = tail.res.qz;
        tail_word.q_parallel   = dpsv_pkg::sat_mag(tail.r[0]);
        tail_word.qz_sum       = tail.res.qs;
        tail_word.qz_diff      = tail.res.qd;
        tail_word.q_total_sum  = dpsv_pkg::sat_mag(tail.r[1]);
        tail_word.q_total_diff = dpsv_pkg::sat_mag(tail.r[2]);
    end

    assign push = ce & sr_v_reg[SS-1];
    assign take = out_v_reg & m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (take)
                skid_v_reg <= 1'b0;
        end
        else if (push)
        begin
            if (!out_v_reg || take)
                out_v_reg <= 1'b1;
            else
                skid_v_reg <= 1'b1;
        end
        else if (take)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (take)
                out_reg <= skid_reg;
        end
        else if (push)
        begin
            if (!out_v_reg || take)
                out_reg <= tail_word;
            else
                skid_reg <= tail_word;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_reg;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid word held with empty output register");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_v_reg) |-> $past(out_v_reg && !m_axis_tready))
        else $error("skid filled without an output stall");

    a_total_ge_par: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |-> (out_reg.q_total_sum >= out_reg.q_parallel)
                      && (out_reg.q_total_diff >= out_reg.q_parallel))
        else $error("total magnitude below in-plane magnitude");
`endif

endmodule

// ----- bench/dpsv_checker.sv -----
// dpsv_checker: watches the pixel, result and register channels of the converter,
// predicts every result word and compares it field by field; depends on dpsv_pkg
module dpsv_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [dpsv_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [dpsv_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic                             pready,
    input  logic [dpsv_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output int                               errors,
    output int                               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import dpsv_pkg::*;

    localparam int ATAN_TAB [30] = '{421657428, 248918915, 131521918, 66762579, 33510843,
        16771758, 8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072, 65536,
        32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
    localparam int FIELD_LSB [10] = '{0, 32, 64, 96, 128, 160, 191, 223, 255, 286};
    localparam int FIELD_W [10] = '{32, 32, 32, 32, 32, 31, 32, 32, 31, 31};
    localparam string FIELD_NAME [10] = '{"exit_theta", "exit_alpha", "q_x", "q_y", "q_z",
        "q_parallel", "qz_sum", "qz_diff", "q_total_sum", "q_total_diff"};

    longint det_width, pitch, bcol, brow, sdist, k0, inc_cos, inc_sin;
    logic [OUT_TDATA_W-1:0] expected_q [$];

    function automatic longint atan_at(int i);
        return (i < 30) ? longint'(ATAN_TAB[i]) : 0;
    endfunction

    function automatic longint vector_angle(longint x, longint y, output longint mag);
        longint z;
        longint xs;
        longint ys;
        longint unsigned u;
        z = 0;
        if (y == 0)
        begin
            mag = (x < 0) ? 0 : x;
            return 0;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x += ys; y -= xs; z += atan_at(i);
            end
            else
            begin
                x -= ys; y += xs; z -= atan_at(i);
            end
        end
        u = (x < 0) ? 0 : x;
        mag = longint'((u >> 32) * 64'(GAIN_Q32) + (((u & 64'hFFFF_FFFF) * 64'(GAIN_Q32)) >> 32));
        return z;
    endfunction

    function automatic void cos_sin(longint z, output longint c, output longint s);
        longint x;
        longint y;
        longint xs;
        longint ys;
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= atan_at(i);
            end
            else
            begin
                x += ys; y -= xs; z += atan_at(i);
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint k_scale(longint v);
        return clamp32((k0 * v) >>> 30);
    endfunction

    function automatic longint unsigned root_mag(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return (r > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : r;
    endfunction

    function automatic logic [OUT_TDATA_W-1:0] scatter_vector(logic [INDEX_BITS-1:0] idx);
        longint row, col, dx, dy, theta, alpha, quad, unused;
        longint ct, st, ca, sa, abs_sa, qx, qy, qz, qs, qd;
        longint unsigned par2;
        out_t o;
        if (det_width == 0)
        begin
            row = 0; col = idx;
        end
        else
        begin
            row = idx / det_width; col = idx % det_width;
        end
        dx = pitch * (col + 1 - bcol);
        dy = pitch * (row + 1 - brow);
        theta = vector_angle(sdist, dx, quad);
        alpha = vector_angle(quad, dy, unused);
        cos_sin(theta, ct, st);
        cos_sin(alpha, ca, sa);
        qx = k_scale(((ca * ct) >>> 30) - inc_cos);
        qy = k_scale((ca * st) >>> 30);
        qz = k_scale(sa + inc_sin);
        abs_sa = (sa < 0) ? -sa : sa;
        qs = k_scale(abs_sa + inc_sin);
        qd = k_scale(inc_sin - abs_sa);
        par2 = longint'(qx * qx) + longint'(qy * qy);
        o = '0;
        o.exit_theta = 32'(clamp32(theta));
        o.exit_alpha = 32'(clamp32(alpha));
        o.q_x = 32'(qx);
        o.q_y = 32'(qy);
        o.q_z = 32'(qz);
        o.q_parallel = 31'(root_mag(par2));
        o.qz_sum = 32'(qs);
        o.qz_diff = 32'(qd);
        o.q_total_sum = 31'(root_mag(par2 + longint'(qs * qs)));
        o.q_total_diff = 31'(root_mag(par2 + longint'(qd * qd)));
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [OUT_TDATA_W-1:0] want;
        longint wv;
        longint gv;
        if (!rst_n)
        begin
            det_width = RST_DETECTOR_WIDTH; pitch = RST_PIXEL_PITCH;
            bcol = RST_BEAM_COL; brow = RST_BEAM_ROW; sdist = RST_SAMPLE_DISTANCE;
            k0 = RST_WAVENUMBER; inc_cos = RST_INCIDENCE_COS; inc_sin = RST_INCIDENCE_SIN;
            expected_q.delete();
            errors = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[CFG_ADDR_W-1:2])
                    REG_DETECTOR_WIDTH:  det_width = pwdata[15:0];
                    REG_PIXEL_PITCH:     pitch = pwdata[23:0];
                    REG_BEAM_COL:        bcol = pwdata[15:0];
                    REG_BEAM_ROW:        brow = pwdata[15:0];
                    REG_SAMPLE_DISTANCE: sdist = pwdata;
                    REG_WAVENUMBER:      k0 = pwdata[30:0];
                    REG_INCIDENCE_COS:   inc_cos = pwdata[30:0];
                    REG_INCIDENCE_SIN:   inc_sin = pwdata[30:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(scatter_vector(s_axis_tdata[INDEX_BITS-1:0]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result word %h", $time, m_axis_tdata);
                end
                else
                begin
                    want = expected_q.pop_front();
                    for (int f = 0; f < 10; f++)
                    begin
                        wv = (want >> FIELD_LSB[f]) & ((64'd1 << FIELD_W[f]) - 1);
                        gv = (m_axis_tdata >> FIELD_LSB[f]) & ((64'd1 << FIELD_W[f]) - 1);
                        if (wv != gv)
                        begin
                            errors++;
                            $display("%0t: %s expected %h actual %h", $time, FIELD_NAME[f],
                                     wv, gv);
                        end
                    end
                end
            end
        end
        outstanding = expected_q.size();
    end

endmodule

// ----- bench/tb_detector_pixel_to_scattering_vector.sv -----
// tb_detector_pixel_to_scattering_vector: stimulus, register settings and verdict
// depends on dpsv_pkg, the converter and dpsv_checker
module tb_detector_pixel_to_scattering_vector;
    timeunit 1ns;
    timeprecision 1ps;
    import dpsv_pkg::*;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata;   // pixel_index
    logic m_axis_tvalid;
    logic m_axis_tready;
    // exit_theta, exit_alpha, q_x, q_y, q_z, q_parallel, qz_sum, qz_diff,
    // q_total_sum, q_total_diff, zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic psel;
    logic penable;
    logic pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    int errors;
    int outstanding;
    int pace;
    int pixels_sent;
    int settings_used;

    detector_pixel_to_scattering_vector u_dut (.*);

    dpsv_checker u_checker (.*);

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_400_000;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (pace == 2)
            m_axis_tready <= ($urandom_range(99) >= 74);
        else if (pace == 3)
            m_axis_tready <= ($urandom_range(99) >= 20);
        else
            m_axis_tready <= 1'b1;
    end

    task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_pixel(logic [INDEX_BITS-1:0] idx);
        int gap_pct;
        logic took;
        gap_pct = (pace == 1) ? 74 : (pace == 3) ? 20 : 0;
        if (gap_pct > 0)
        begin
            while ($urandom_range(99) < gap_pct)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= idx;
        do
        begin
            @(negedge clk);
            took = s_axis_tready;
            @(posedge clk);
        end
        while (!took);
        pixels_sent++;
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic load_setting(int w, int p, int bc, int br, longint sd, int k,
                                int c, int s);
        reg_write(REG_DETECTOR_WIDTH, w);
        reg_write(REG_PIXEL_PITCH, p);
        reg_write(REG_BEAM_COL, bc);
        reg_write(REG_BEAM_ROW, br);
        reg_write(REG_SAMPLE_DISTANCE, 32'(sd));
        reg_write(REG_WAVENUMBER, k);
        reg_write(REG_INCIDENCE_COS, c);
        reg_write(REG_INCIDENCE_SIN, s);
        settings_used++;
    endtask

    task automatic random_pixels(int n, int w);
        int row;
        int col;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(1) == 0 || w == 0)
                send_pixel(24'($urandom));
            else
            begin
                row = $urandom_range(2047);
                col = $urandom_range(w - 1);
                send_pixel(24'(row * w + col));
            end
        end
    endtask

    initial
    begin
        int w;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        pace = 0;
        pixels_sent = 0;
        settings_used = 1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default geometry: corners, the direct beam pixel and its neighbors
        send_pixel(24'd0);
        send_pixel(24'hFF_FFFF);
        send_pixel(24'd511 * 24'd1024 + 24'd511);
        send_pixel(24'd511 * 24'd1024 + 24'd512);
        send_pixel(24'd512 * 24'd1024 + 24'd511);
        send_pixel(24'd1023);
        send_pixel(24'd1024);
        send_pixel(24'h55_5555);
        send_pixel(24'hAA_AAAA);
        drain();

        // zero width, zero distance, and the widest values
        load_setting(0, 24'hFF_FFFF, 0, 0, 0, 31'h7FFF_FFFF, 0, 31'h4000_0000);
        send_pixel(24'd0);
        send_pixel(24'd1);
        send_pixel(24'hFF_FFFF);
        send_pixel(24'h80_0000);
        drain();
        load_setting(1, 1, 16'hFFFF, 16'hFFFF, 65536, 0, 31'h4000_0000, 0);
        send_pixel(24'd0);
        send_pixel(24'hFF_FFFF);
        send_pixel(24'd65534);
        drain();
        load_setting(16'hFFFF, 24'hFF_FFFF, 16'hFFFF, 0, 32'hFFFF_FFFF, 31'h7FFF_FFFF,
                     31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_pixel(24'd65534);
        send_pixel(24'hFF_FFFF);
        send_pixel(24'd0);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            pace = ph % 4;
            case ($urandom_range(3))
                0: w = 0;
                1: w = $urandom_range(1, 16);
                default: w = $urandom_range(1, 4096);
            endcase
            load_setting(w, $urandom_range(1, 24'hFF_FFFF), $urandom_range(0, 2048),
                         $urandom_range(0, 2048), $urandom_range(65536, 32'hFFFF_FFFF),
                         $urandom_range(0, 31'h7FFF_FFFF), $urandom_range(0, 31'h4000_0000),
                         $urandom_range(0, 31'h4000_0000));
            random_pixels(145, w);
            drain();
        end

        s_axis_tvalid <= 1'b0;
        repeat (200) @(posedge clk);
        $display("sent %0d pixels under %0d register settings, four pacing modes",
                 pixels_sent, settings_used);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/dpsv_pkg.sv
hdl/detector_pixel_to_scattering_vector.sv
bench/dpsv_checker.sv
bench/tb_detector_pixel_to_scattering_vector.sv
